// File: design/rainbow_wheel_pixel_generator_defines.svh
// Assertion macros shared by the rainbow wheel pixel generator.
`ifndef RAINBOW_WHEEL_PIXEL_GENERATOR_DEFINES_SVH
`define RAINBOW_WHEEL_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define RWPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset.
`define RWPG_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rwpg_pkg.sv
// Package with shared constants and types of the rainbow wheel pixel generator.
package rwpg_pkg;

  localparam int LED_COUNT_DEF   = 300;
  localparam int SEGMENT_LEN_DEF = 50;

  localparam int LEVEL_W    = 8;
  localparam int CFG_ADDR_W = 1;

  localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = 8'd63;
  localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOW_LEVEL  = 1'b0,
    REG_HIGH_LEVEL = 1'b1
  } cfg_reg_t;

  // Color wheel segments, named after the hues they blend between.
  typedef enum logic [2:0] {
    SEG_RED_YEL = 3'd0,
    SEG_YEL_GRN = 3'd1,
    SEG_GRN_CYN = 3'd2,
    SEG_CYN_BLU = 3'd3,
    SEG_BLU_MAG = 3'd4,
    SEG_MAG_RED = 3'd5
  } seg_t;

endpackage

// File: design/rwpg_wheel.sv
// Wheel position, phase and pixel counters plus the first pipeline register.
module rwpg_wheel
  import rwpg_pkg::*;
#(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int SEGMENT_LEN = SEGMENT_LEN_DEF,
  localparam int POS_W      = $clog2(LED_COUNT),
  localparam int PHASE_W    = (SEGMENT_LEN > 1) ? $clog2(SEGMENT_LEN) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               frame_start,
  input  logic               dir_forward,
  input  logic               dim,
  input  logic [LEVEL_W-1:0] low_level,
  input  logic [LEVEL_W-1:0] high_level,
  output logic               a_valid,
  input  logic               a_ready,
  output logic [LEVEL_W-1:0] a_level,
  output logic [PHASE_W-1:0] a_phase,
  output seg_t               a_seg,
  output logic               a_last
);

  localparam logic [POS_W-1:0]   POS_LAST = POS_W'(LED_COUNT - 1);
  localparam logic [POS_W-1:0]   QUO_LAST = POS_W'((LED_COUNT - 1) / SEGMENT_LEN);
  localparam logic [PHASE_W-1:0] REM_WRAP = PHASE_W'((LED_COUNT - 1) % SEGMENT_LEN);
  localparam logic [PHASE_W-1:0] PH_LAST  = PHASE_W'(SEGMENT_LEN - 1);

  // The position is kept together with its quotient and remainder by the
  // segment length, so a step never needs a divider.
  logic [POS_W-1:0]   wheel_pos, wheel_pos_next;
  logic [POS_W-1:0]   wheel_quo, wheel_quo_next;
  logic [PHASE_W-1:0] wheel_rem, wheel_rem_next;
  logic [PHASE_W-1:0] ramp_phase, ramp_phase_next;
  seg_t               segment, segment_next;
  logic [POS_W-1:0]   pixel_count, pixel_count_next;
  logic [LEVEL_W-1:0] frame_level;

  logic               accept;
  logic [LEVEL_W-1:0] cur_level;
  logic [PHASE_W-1:0] cur_phase;
  seg_t               cur_seg;
  logic [POS_W-1:0]   cur_count;
  logic               cur_last;

  assign in_ready = !a_valid || a_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    wheel_pos_next = wheel_pos;
    wheel_quo_next = wheel_quo;
    wheel_rem_next = wheel_rem;
    if (dir_forward) begin
      if (wheel_pos == POS_LAST) begin
        wheel_pos_next = '0;
        wheel_quo_next = '0;
        wheel_rem_next = '0;
      end else begin
        wheel_pos_next = wheel_pos + POS_W'(1);
        if (wheel_rem == PH_LAST) begin
          wheel_rem_next = '0;
          wheel_quo_next = wheel_quo + POS_W'(1);
        end else begin
          wheel_rem_next = wheel_rem + PHASE_W'(1);
        end
      end
    end else begin
      if (wheel_pos == '0) begin
        wheel_pos_next = POS_LAST;
        wheel_quo_next = QUO_LAST;
        wheel_rem_next = REM_WRAP;
      end else begin
        wheel_pos_next = wheel_pos - POS_W'(1);
        if (wheel_rem == '0) begin
          wheel_rem_next = PH_LAST;
          wheel_quo_next = wheel_quo - POS_W'(1);
        end else begin
          wheel_rem_next = wheel_rem - PHASE_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (frame_start) begin
      cur_level = dim ? low_level : high_level;
      cur_phase = wheel_rem_next;
      cur_seg   = (wheel_quo_next > POS_W'(SEG_MAG_RED)) ? SEG_MAG_RED
                                                         : seg_t'(wheel_quo_next[2:0]);
      cur_count = '0;
    end else begin
      cur_level = frame_level;
      cur_phase = ramp_phase;
      cur_seg   = segment;
      cur_count = pixel_count;
    end
    cur_last         = (cur_count >= POS_LAST);
    pixel_count_next = cur_last ? '0 : cur_count + POS_W'(1);
    if (cur_phase >= PH_LAST) begin
      ramp_phase_next = '0;
      segment_next    = (cur_seg == SEG_MAG_RED) ? SEG_RED_YEL : seg_t'(cur_seg + 3'd1);
    end else begin
      ramp_phase_next = cur_phase + PHASE_W'(1);
      segment_next    = cur_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_pos   <= '0;
      wheel_quo   <= '0;
      wheel_rem   <= '0;
      ramp_phase  <= '0;
      segment     <= SEG_RED_YEL;
      pixel_count <= '0;
      frame_level <= '0;
      a_valid     <= 1'b0;
    end else begin
      if (accept) begin
        ramp_phase  <= ramp_phase_next;
        segment     <= segment_next;
        pixel_count <= pixel_count_next;
        if (frame_start) begin
          wheel_pos   <= wheel_pos_next;
          wheel_quo   <= wheel_quo_next;
          wheel_rem   <= wheel_rem_next;
          frame_level <= cur_level;
        end
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_level <= cur_level;
      a_phase <= cur_phase;
      a_seg   <= cur_seg;
      a_last  <= cur_last;
    end
  end

endmodule

// File: design/rwpg_shade.sv
// Ramp product, division by the segment length and the channel select.
module rwpg_shade
  import rwpg_pkg::*;
#(
  parameter int SEGMENT_LEN = SEGMENT_LEN_DEF,
  localparam int PHASE_W    = (SEGMENT_LEN > 1) ? $clog2(SEGMENT_LEN) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               a_valid,
  output logic               a_ready,
  input  logic [LEVEL_W-1:0] a_level,
  input  logic [PHASE_W-1:0] a_phase,
  input  seg_t               a_seg,
  input  logic               a_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] red,
  output logic [LEVEL_W-1:0] green,
  output logic [LEVEL_W-1:0] blue,
  output logic               last
);

  // Exact floor division of a PROD_W-bit value by the segment length through
  // a reciprocal of PROD_W+1 bits and a shift of PROD_W+ceil(log2(len)).
  localparam int PROD_W  = LEVEL_W + PHASE_W;
  localparam int SHIFT   = PROD_W + $clog2(SEGMENT_LEN);
  localparam int RECIP_W = PROD_W + 1;
  localparam int FULL_W  = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(SEGMENT_LEN) - 64'd1) / 64'(SEGMENT_LEN));

  logic               b_valid;
  logic               b_ready;
  logic [PROD_W-1:0]  b_prod;
  logic [LEVEL_W-1:0] b_level;
  seg_t               b_seg;
  logic               b_last;

  logic [PROD_W-1:0]  prod_next;
  logic [FULL_W-1:0]  scaled;
  logic [LEVEL_W-1:0] quo;
  logic [LEVEL_W-1:0] ramp;
  logic [LEVEL_W-1:0] fall;
  logic [LEVEL_W-1:0] red_next, green_next, blue_next;

  assign a_ready   = !b_valid || b_ready;
  assign b_ready   = !out_valid || out_ready;
  assign prod_next = PROD_W'(a_level) * PROD_W'(a_phase);

  assign scaled = FULL_W'(b_prod) * FULL_W'(RECIP);
  assign quo    = scaled[SHIFT +: LEVEL_W];
  assign ramp   = (quo > b_level) ? b_level : quo;
  assign fall   = b_level - ramp;

  always_comb begin
    unique case (b_seg)
      SEG_RED_YEL: begin
        red_next = b_level; green_next = ramp;    blue_next = '0;
      end
      SEG_YEL_GRN: begin
        red_next = fall;    green_next = b_level; blue_next = '0;
      end
      SEG_GRN_CYN: begin
        red_next = '0;      green_next = b_level; blue_next = ramp;
      end
      SEG_CYN_BLU: begin
        red_next = '0;      green_next = fall;    blue_next = b_level;
      end
      SEG_BLU_MAG: begin
        red_next = ramp;    green_next = '0;      blue_next = b_level;
      end
      default: begin
        red_next = b_level; green_next = '0;      blue_next = fall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        b_valid <= a_valid;
      end
      if (b_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      b_prod  <= prod_next;
      b_level <= a_level;
      b_seg   <= a_seg;
      b_last  <= a_last;
    end
    if (b_valid && b_ready) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
      last  <= b_last;
    end
  end

endmodule

// File: design/rainbow_wheel_pixel_generator.sv
// Top level of the rainbow wheel pixel generator: configuration and pipeline.
//
//   Channel   Direction  Transfer when             Carries
//   s_axis    in         s_axis_tvalid & tready   wheel control for one pixel
//   m_axis    out        m_axis_tvalid & tready   one RGB pixel, tlast at strip end
//   cfg       in         cfg_we                   low / high brightness level
//
// One pixel is accepted per clock cycle, sustained, while the output is not
// stalled; its result passes the wheel counters, the ramp product, then
// the reciprocal multiply and channel select into the output register.
// Each of the three register stages has its own valid bit, so a stalled
// output only holds back the stages behind it once they are full.
// Reset is synchronous and active high; it clears the wheel state, the
// stage valid bits and loads the default brightness levels.
module rainbow_wheel_pixel_generator
  import rwpg_pkg::*;
#(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int SEGMENT_LEN = SEGMENT_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input pixel stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] dir_forward, [1] dim, rest zero
  input  logic                  s_axis_tuser,   // [0] frame_start
  // Output pixel stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                  m_axis_tlast,   // last_in_frame
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LEVEL_W-1:0]    cfg_data
);

`include "rainbow_wheel_pixel_generator_defines.svh"

  localparam int PHASE_W = (SEGMENT_LEN > 1) ? $clog2(SEGMENT_LEN) : 1;

  logic [LEVEL_W-1:0] low_level;
  logic [LEVEL_W-1:0] high_level;

  logic               a_valid;
  logic               a_ready;
  logic [LEVEL_W-1:0] a_level;
  logic [PHASE_W-1:0] a_phase;
  seg_t               a_seg;
  logic               a_last;

  logic [LEVEL_W-1:0] red, green, blue;

  // Brightness levels; writes are only expected while the stream is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_level  <= LOW_LEVEL_RST;
      high_level <= HIGH_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_LOW_LEVEL:  low_level  <= cfg_data;
        REG_HIGH_LEVEL: high_level <= cfg_data;
      endcase
    end
  end

  // Stage one: the wheel position moves on frame start, then the phase and
  // segment for this pixel are registered along with the end-of-strip flag.
  rwpg_wheel #(
    .LED_COUNT   (LED_COUNT),
    .SEGMENT_LEN (SEGMENT_LEN)
  ) u_wheel (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .frame_start (s_axis_tuser),
    .dir_forward (s_axis_tdata[0]),
    .dim         (s_axis_tdata[1]),
    .low_level   (low_level),
    .high_level  (high_level),
    .a_valid     (a_valid),
    .a_ready     (a_ready),
    .a_level     (a_level),
    .a_phase     (a_phase),
    .a_seg       (a_seg),
    .a_last      (a_last)
  );

  // Stages two and three: level times phase, divided by the segment length,
  // then the six-way select of level, ramp and level minus ramp.
  rwpg_shade #(
    .SEGMENT_LEN (SEGMENT_LEN)
  ) u_shade (
    .clk       (clk),
    .rst       (rst),
    .a_valid   (a_valid),
    .a_ready   (a_ready),
    .a_level   (a_level),
    .a_phase   (a_phase),
    .a_seg     (a_seg),
    .a_last    (a_last),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (m_axis_tlast)
  );

  assign m_axis_tdata = {blue, green, red};

  // An empty output register means the pipeline cannot be backed up.
  `RWPG_ASSERT_NOW(a_ready_when_out_empty, clk, rst, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
  // Every wheel segment drives one channel to zero.
  `RWPG_ASSERT_NOW(a_one_channel_dark, clk, rst, m_axis_tvalid, (red == '0) || (green == '0) || (blue == '0), "pixel with no dark channel")
  // Reset empties the pipeline.
  `RWPG_ASSERT_NEXT(a_reset_flushes, clk, rst, !m_axis_tvalid, "output valid right after reset")

endmodule

// File: bench/tb_rainbow_wheel_pixel_generator.sv
// Self-checking testbench for the rainbow wheel pixel generator.
module tb_rainbow_wheel_pixel_generator
  import rwpg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The settle time covers the pipeline and adds a little margin so that a
  // stray late pixel is still caught.
  localparam int PIPE_LATENCY    = 3;
  localparam int SETTLE_CYCLES   = PIPE_LATENCY + 5;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 327;
  localparam int HOLD_CYCLES     = 64;
  localparam int BURST_LEN       = 80;
  // Slowest correct run: about 1650 pixels, each behind the longest sender gap
  // and the longest receiver stall, plus the pipeline.
  localparam int CYCLE_LIMIT     = 600000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic   start;
    logic   fwd;
    logic   dm;
    logic   typed;
    pixel_t want;
  } stim_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_addr = REG_LOW_LEVEL;
  logic [LEVEL_W-1:0]    cfg_data = '0;

  rainbow_wheel_pixel_generator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] dir_forward, [1] dim, rest zero
    .s_axis_tuser  (s_axis_tuser),   // [0] frame_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] red, [15:8] green, [23:16] blue
    .m_axis_tlast  (m_axis_tlast),   // last_in_frame
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Our own copy of the wheel state and of the two brightness registers.
  logic [8:0]         wheel_pos   = '0;
  logic [5:0]         wheel_phase = '0;
  seg_t               wheel_seg   = SEG_RED_YEL;
  logic [8:0]         strip_count = '0;
  logic [LEVEL_W-1:0] frame_level = '0;
  logic [LEVEL_W-1:0] low_lvl     = LOW_LEVEL_RST;
  logic [LEVEL_W-1:0] high_lvl    = HIGH_LEVEL_RST;

  // Pixels still owed by the block, oldest first.
  pixel_t pixel_q[$];
  int     errors = 0;
  int     cycle_count = 0;

  // Knobs shared between the stimulus and the receiver.
  logic idle_on  = 1'b1;   // random gaps on both sides
  logic burst    = 1'b0;   // sender offers back to back regardless of idle_on
  logic hold_req = 1'b0;   // receiver holds off for HOLD_CYCLES

  // Directed rows. Some rows have their pixel typed in: black before any
  // frame start, then single steps around position zero where the ramp is
  // trivial to work out by hand. The rest go through the predictor.
  stim_row_t directed_rows [14] = '{
    // Before the first frame the level is zero, so the pixel is black.
    '{1'b0, 1'b0, 1'b0, 1'b1, '{8'd0,   8'd0, 8'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, 1'b1, '{8'd0,   8'd0, 8'd0, 1'b0}},
    // Step forward to position 1 at full level: ramp is 255 * 1 / 50.
    '{1'b1, 1'b1, 1'b0, 1'b1, '{8'd255, 8'd5, 8'd0, 1'b0}},
    // Step back to position 0.
    '{1'b1, 1'b0, 1'b0, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b0}},
    // Step back past zero to the last LED, dim level, last phase of the last
    // segment: ramp is 63 * 49 / 50 = 61, so blue is 63 - 61.
    '{1'b1, 1'b0, 1'b1, 1'b1, '{8'd63,  8'd0, 8'd2, 1'b0}},
    // The segment now wraps from the last back to the first.
    '{1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b1, 1'b0, '0},
    // Step forward past the last LED back to position 0.
    '{1'b1, 1'b1, 1'b1, 1'b1, '{8'd63,  8'd0, 8'd0, 1'b0}},
    '{1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b1, 1'b0, '0},
    // A frame start in the middle of a count restarts the strip.
    '{1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b1, 1'b0, '0}
  };

  // Works out the pixel for one accepted input and advances the wheel.
  function automatic pixel_t next_wheel_pixel(input logic start, input logic fwd,
                                              input logic dm);
    pixel_t px;
    int     pos;
    int     lvl;
    int     ramp;
    int     fade;
    if (start) begin
      pos = int'(wheel_pos) % LED_COUNT_DEF;
      if (fwd) pos = (pos + 1) % LED_COUNT_DEF;
      else     pos = (pos == 0) ? LED_COUNT_DEF - 1 : pos - 1;
      wheel_pos   = 9'(pos);
      frame_level = dm ? low_lvl : high_lvl;
      // Positions past six whole segments stay in the last one.
      wheel_seg   = (pos / SEGMENT_LEN_DEF > 5) ? SEG_MAG_RED
                                                : seg_t'(pos / SEGMENT_LEN_DEF);
      wheel_phase = 6'(pos % SEGMENT_LEN_DEF);
      strip_count = '0;
    end

    lvl  = int'(frame_level);
    ramp = (lvl * int'(wheel_phase)) / SEGMENT_LEN_DEF;
    if (ramp > lvl) ramp = lvl;
    fade = lvl - ramp;

    case (wheel_seg)
      SEG_RED_YEL: px = '{8'(lvl),  8'(ramp), 8'd0,     1'b0};
      SEG_YEL_GRN: px = '{8'(fade), 8'(lvl),  8'd0,     1'b0};
      SEG_GRN_CYN: px = '{8'd0,     8'(lvl),  8'(ramp), 1'b0};
      SEG_CYN_BLU: px = '{8'd0,     8'(fade), 8'(lvl),  1'b0};
      SEG_BLU_MAG: px = '{8'(ramp), 8'd0,     8'(lvl),  1'b0};
      default:     px = '{8'(lvl),  8'd0,     8'(fade), 1'b0};
    endcase

    px.last     = (int'(strip_count) >= LED_COUNT_DEF - 1);
    strip_count = px.last ? 9'd0 : strip_count + 9'd1;

    wheel_phase = wheel_phase + 6'd1;
    if (int'(wheel_phase) >= SEGMENT_LEN_DEF) begin
      wheel_phase = '0;
      wheel_seg   = (wheel_seg == SEG_MAG_RED) ? SEG_RED_YEL : seg_t'(wheel_seg + 1);
    end
    return px;
  endfunction

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one input item, waits for its transfer and records the pixel it
  // owes. Called on a rising edge; returns on the edge of the transfer or
  // after the gap that follows it. tvalid only drops when a gap follows, so
  // back-to-back items keep it high with a single assignment per edge.
  task automatic send_pixel(input logic start, input logic fwd, input logic dm,
                            input logic typed, input pixel_t want);
    pixel_t pred;
    int     gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= {6'b0, dm, fwd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = next_wheel_pixel(start, fwd, dm);
    pixel_q.push_back(typed ? want : pred);
    gap = (idle_on && !burst) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every owed pixel come out, then waits SETTLE_CYCLES more, so that the
  // block is idle before a register write or the end of the run.
  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the low and then the high brightness register on consecutive edges.
  task automatic write_levels(input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_LOW_LEVEL;
    cfg_data <= lo;
    @(posedge clk);
    cfg_addr <= REG_HIGH_LEVEL;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    low_lvl  = lo;
    high_lvl = hi;
  endtask

  // Compares one field of a pixel and reports a mismatch.
  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver. Random stalls while idling is on, always ready otherwise, and
  // one long hold-off on request. During the hold-off the sender keeps
  // offering, so the pipeline fills and the block has to stall its input.
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = idle_on ? pick_gap() : 0;
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Output checker: every pixel transfer is matched against the oldest
  // owed pixel, field by field.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, got data %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pixel_q.pop_front();
        check_channel("red",   want.red,   m_axis_tdata[7:0]);
        check_channel("green", want.green, m_axis_tdata[15:8]);
        check_channel("blue",  want.blue,  m_axis_tdata[23:16]);
        check_channel("last",  {7'b0, want.last}, {7'b0, m_axis_tlast});
      end
    end
  end

  // Watchdog on a plain cycle counter.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rainbow_wheel_pixel_generator test failed");
    $finish;
  end

  // Stimulus. A short directed walk around position zero, then five phases of
  // random frames, each under its own brightness setting. A frame is a
  // frame-start item followed by a run of plain pixels: usually a short run
  // so that the wheel position travels, sometimes exactly one strip so that
  // the last flag lands on the final pixel, and sometimes longer than a strip
  // so that the pixel count wraps without a new frame. The last frame of a
  // phase is cut short so that every phase sends the same number of items.
  initial begin
    int        phase_items;
    int        run;
    int        room;
    int        kind;
    int        fwd_pct;
    logic      fwd;
    stim_row_t row;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_pixel(row.start, row.fwd, row.dm, row.typed, row.want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Phase 0 keeps the reset levels; the others take both extremes,
      // a near-extreme pair and random values.
      if (ph > 0) begin
        drain_pixels();
        case (ph)
          1:       write_levels(8'd0, 8'd255);
          2:       write_levels(8'd255, 8'd0);
          4:       write_levels(8'd1, 8'd254);
          default: write_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        endcase
      end
      // Phase 3 runs with no idling on either side at all.
      idle_on     = (ph != 3);
      // Alternate the walking direction so that both wraps of the position
      // are crossed again and again.
      fwd_pct     = (ph % 2 == 1) ? 25 : 80;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        // First frame of phase 1: the receiver holds off while the sender
        // streams without gaps.
        burst = (ph == 1 && phase_items == 0);
        if (burst) hold_req = 1'b1;
        kind = $urandom_range(0, 5);
        if (burst)          run = BURST_LEN;
        else if (kind == 0) run = LED_COUNT_DEF - 1;
        else if (kind == 1) run = LED_COUNT_DEF + $urandom_range(0, 20);
        else                run = $urandom_range(0, 15);
        room = ITEMS_PER_PHASE - phase_items - 1;
        if (run > room) run = room;
        fwd = ($urandom_range(0, 99) < fwd_pct);
        send_pixel(1'b1, fwd, 1'($urandom_range(0, 1)), 1'b0, '0);
        // Plain pixels carry random direction and dim bits, which the block
        // must ignore outside a frame start.
        for (int k = 0; k < run; k++)
          send_pixel(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        burst = 1'b0;
        phase_items += run + 1;
      end
    end

    drain_pixels();
    if (errors == 0)
      $display("rainbow_wheel_pixel_generator test passed");
    else
      $display("rainbow_wheel_pixel_generator test failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/rwpg_pkg.sv
design/rwpg_wheel.sv
design/rwpg_shade.sv
design/rainbow_wheel_pixel_generator.sv
bench/tb_rainbow_wheel_pixel_generator.sv
